### sv/mpd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package mpd_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_FORMAT = 1'b1;

  // Packet format codes
  localparam logic [1:0] FMT_STANDARD = 2'd0;
  localparam logic [1:0] FMT_WHEEL    = 2'd1;
  localparam logic [1:0] FMT_EXPLORER = 2'd2;

  // Event kinds; each kind is also its bit position in the pending mask
  localparam logic [3:0] EV_X      = 4'd0;
  localparam logic [3:0] EV_Y      = 4'd1;
  localparam logic [3:0] EV_WHEEL  = 4'd2;
  localparam logic [3:0] EV_LEFT   = 4'd3;
  localparam logic [3:0] EV_RIGHT  = 4'd4;
  localparam logic [3:0] EV_MIDDLE = 4'd5;
  localparam logic [3:0] EV_SIDE   = 4'd6;
  localparam logic [3:0] EV_EXTRA  = 4'd7;
  localparam logic [3:0] EV_SYNC   = 4'd8;

  localparam int unsigned NUM_EV   = 9;
  localparam int unsigned NUM_BTN  = 5;

  // Sync bit of the first packet byte
  localparam int unsigned SYNC_BIT = 3;

  // Default depth of the packet queue
  localparam int unsigned MPD_QUEUE_DEPTH = 2;

  // One decoded packet, as handed from the front end to the back end
  typedef struct packed {
    logic [NUM_EV-1:0]  mask;     // events still to be sent
    logic signed [9:0]  x_val;
    logic signed [9:0]  y_val;    // already negated
    logic signed [9:0]  w_val;    // already negated
    logic [NUM_BTN-1:0] buttons;  // new button levels
  } mpd_rec_t;

endpackage

### sv/mpd_front.sv
// Front end: configuration, byte assembly and packet decoding.
module mpd_front
  import mpd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [1:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           queue_full_i,
  output logic           push_o,
  output mpd_rec_t       rec_o
);

  logic       enable_q;
  logic [1:0] format_q;
  logic [1:0] pos_q, pos_d;
  logic [NUM_BTN-1:0] btn_q, btn_d;
  logic [7:0] store_q [3];

  logic accept, drop, complete, size4, explorer, ovf;
  logic [7:0] flags, y_byte, f_byte;
  logic signed [9:0] x10, y10, w10;
  logic [NUM_BTN-1:0] nb, changed;

  // Stall only while the queue cannot take a packet
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign size4    = (format_q == FMT_WHEEL) || (format_q == FMT_EXPLORER);
  assign explorer = (format_q == FMT_EXPLORER);
  assign drop     = !enable_q || ((pos_q == 2'd0) && !data_byte_i[SYNC_BIT]);
  assign complete = (pos_q == 2'd3) || ((pos_q == 2'd2) && !size4);

  // Gather the packet bytes; the final byte is taken straight from the port
  assign flags  = store_q[0];
  assign y_byte = (pos_q == 2'd2) ? data_byte_i : store_q[2];
  assign f_byte = size4 ? data_byte_i : 8'h00;
  assign ovf    = flags[7] || flags[6];

  // Decode motion, wheel and buttons
  always_comb begin
    x10 = ovf ? 10'sd0 : $signed({flags[4], flags[4], store_q[1]});
    y10 = ovf ? 10'sd0 : $signed({flags[5], flags[5], y_byte});
    if (explorer) begin
      w10 = $signed({{6{f_byte[3]}}, f_byte[3:0]});
    end else if (size4) begin
      w10 = $signed({{2{f_byte[7]}}, f_byte});
    end else begin
      w10 = 10'sd0;
    end
    nb      = {explorer && f_byte[5], explorer && f_byte[4], flags[2:0]};
    changed = nb ^ btn_q;
  end

  always_comb begin
    rec_o.x_val   = x10;
    rec_o.y_val   = 10'sd0 - y10;
    rec_o.w_val   = 10'sd0 - w10;
    rec_o.buttons = nb;
    rec_o.mask    = {1'b1, changed, (w10 != 10'sd0), (y10 != 10'sd0), (x10 != 10'sd0)};
  end

  // Push only packets that carry a change
  assign push_o = accept && !drop && complete && (rec_o.mask[NUM_EV-2:0] != '0);

  // Advance the byte position and the button levels
  always_comb begin
    pos_d = pos_q;
    btn_d = btn_q;
    if (accept && !drop) begin
      if (complete) begin
        pos_d = 2'd0;
        btn_d = nb;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      format_q <= FMT_STANDARD;
      pos_q    <= 2'd0;
      btn_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_ENABLE)) begin
        enable_q <= cfg_data_i[0];
      end
      if (cfg_we_i && (cfg_index_i == CFG_FORMAT)) begin
        format_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      btn_q <= btn_d;
    end
  end

  // Hold the bytes of the packet so far
  always_ff @(posedge clk_i) begin
    if (accept && !drop && !complete) begin
      store_q[pos_q] <= data_byte_i;
    end
  end

endmodule

### sv/mpd_fifo.sv
// Packet queue between the front end and the back end.
module mpd_fifo
  import mpd_pkg::*;
#(
  parameter int unsigned Depth = MPD_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mpd_rec_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output mpd_rec_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mpd_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store the pushed packet
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("packet pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("packet popped from an empty queue");
`endif

endmodule

### sv/mpd_back.sv
// Back end: sends the events of each queued packet, one per transfer.
module mpd_back
  import mpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mpd_rec_t          q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        event_kind_o,
  output logic signed [9:0] event_value_o,
  output logic              last_o
);

  logic     work_valid_q, work_valid_d;
  mpd_rec_t work_q, work_d;
  logic     out_valid_q;
  logic [3:0] kind_q, sel;
  logic signed [9:0] value_q, value_d;
  logic     out_free, emit;
  logic [NUM_EV-1:0] rest;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = work_valid_q && out_free;

  // Pick the lowest pending event
  always_comb begin
    sel = EV_SYNC;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (work_q.mask[i]) begin
        sel = 4'(i);
      end
    end
  end

  assign rest  = work_q.mask & ~(NUM_EV'(1) << sel);
  assign pop_o = q_valid_i && (!work_valid_q || (emit && (rest == '0)));

  // Select the event value
  always_comb begin
    case (sel) inside
      EV_X:     value_d = work_q.x_val;
      EV_Y:     value_d = work_q.y_val;
      EV_WHEEL: value_d = work_q.w_val;
      EV_LEFT, EV_RIGHT, EV_MIDDLE, EV_SIDE, EV_EXTRA:
                value_d = {9'd0, work_q.buttons[3'(sel - EV_LEFT)]};
      default:  value_d = 10'sd0;
    endcase
  end

  // Load the next packet or retire the sent event
  always_comb begin
    work_valid_d = work_valid_q;
    work_d       = work_q;
    if (emit) begin
      work_d.mask  = rest;
      work_valid_d = (rest != '0);
    end
    if (pop_o) begin
      work_valid_d = 1'b1;
      work_d       = q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      if (out_free) begin
        out_valid_q <= work_valid_q;
      end
    end
  end

  // Hold the packet being sent and the output payload
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (emit) begin
      kind_q  <= sel;
      value_q <= value_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_value_o = value_q;
  assign last_o        = (kind_q == EV_SYNC);

`ifndef NO_ASSERTIONS
  a_work_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q |-> work_q.mask[EV_SYNC]) else $error("packet in work lost its sync event");
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && work_valid_q) |-> (emit && (sel == EV_SYNC)))
    else $error("packet loaded over one still being sent");
`endif

endmodule

### sv/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder: top level joining front end, queue and back end.
//
// Takes one byte from the mouse port per transfer, at up to one transfer per
// cycle; the input stalls only while the packet queue (Depth packets) is full.
// A completed packet that carries any change yields two to nine events, sent
// from an output register at one transfer per cycle unless out_stall_i holds
// it, closed by a sync report with last set; the back end moves straight from
// one packet's sync report to the next packet's first event. Format and enable
// are to be written by the user only while idle; the block does not enforce it.
module ps2_mouse_packet_decoder
  import mpd_pkg::*;
#(
  parameter int unsigned Depth = MPD_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [1:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        event_kind_o,
  output logic signed [9:0] event_value_o,
  output logic              last_o
);

  mpd_rec_t push_rec, pop_rec;
  logic     push, pop, q_full, q_valid;

  mpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  mpd_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_rec)
  );

  mpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (pop_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_value_o (event_value_o),
    .last_o        (last_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the PS/2 mouse packet decoder.
module tb_top;
  import mpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // Format code with no meaning of its own; the block decodes it as standard
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0]        kind;
    logic signed [9:0] value;
    logic              last_flag;
  } mouse_event_t;

  // Track decoder state and hold the events each completed packet should yield
  class mouse_event_board;
    bit           enable;
    logic [1:0]   fmt;
    logic [7:0]   store [3];
    int unsigned  pos;
    logic [4:0]   buttons;
    mouse_event_t pending_events [$];
    int unsigned  errors;
    int unsigned  packets_done;
    int unsigned  events_checked;

    function new();
      enable         = 1'b0;
      fmt            = FMT_STANDARD;
      store          = '{default: 8'h00};
      pos            = 0;
      buttons        = '0;
      errors         = 0;
      packets_done   = 0;
      events_checked = 0;
    endfunction

    function void write_reg(logic idx, logic [1:0] val);
      if (idx == CFG_ENABLE) begin
        enable = val[0];
      end else begin
        fmt = val;
      end
    endfunction

    function void push_event(logic [3:0] kind, int value, logic last_flag);
      mouse_event_t ev;
      ev.kind      = kind;
      ev.value     = 10'(value);
      ev.last_flag = last_flag;
      pending_events.push_back(ev);
    endfunction

    // Note one accepted byte; queue the events it causes
    function void decode_byte(logic [7:0] b);
      int unsigned size;
      logic [7:0]  pkt [4];
      int          x;
      int          y;
      int          wheel;
      logic [4:0]  nb;
      logic [4:0]  changed;
      size = (fmt == FMT_WHEEL || fmt == FMT_EXPLORER) ? 4 : 3;
      if (!enable) return;
      if (pos == 0 && !b[SYNC_BIT]) return;
      if (pos + 1 < size) begin
        store[pos] = b;
        pos = pos + 1;
        return;
      end
      // Complete the packet, also when a format change left us beyond its end
      pkt = '{default: 8'h00};
      for (int i = 0; i < int'(pos) && i < 3; i++) pkt[i] = store[i];
      pkt[pos] = b;
      pos = 0;
      packets_done++;

      nb    = {2'b00, pkt[0][2:0]};
      x     = int'(pkt[1]) - (pkt[0][4] ? 256 : 0);
      y     = int'(pkt[2]) - (pkt[0][5] ? 256 : 0);
      wheel = 0;
      if (size == 4) begin
        if (fmt == FMT_EXPLORER) begin
          wheel = int'($signed(pkt[3][3:0]));
          nb[3] = pkt[3][4];
          nb[4] = pkt[3][5];
        end else begin
          wheel = int'($signed(pkt[3]));
        end
      end
      // Drop motion when either overflow bit is set
      if (pkt[0][7:6] != 2'b00) begin
        x = 0;
        y = 0;
      end
      changed = nb ^ buttons;
      if (x == 0 && y == 0 && wheel == 0 && changed == '0) return;

      if (x != 0) push_event(EV_X, x, 1'b0);
      if (y != 0) push_event(EV_Y, -y, 1'b0);
      if (wheel != 0) push_event(EV_WHEEL, -wheel, 1'b0);
      for (int i = 0; i < 5; i++) begin
        if (changed[i]) push_event(EV_LEFT + 4'(i), int'(nb[i]), 1'b0);
      end
      buttons = nb;
      push_event(EV_SYNC, 0, 1'b1);
    endfunction

    // Compare one accepted event with the oldest one waiting
    function void check_event(logic [3:0] kind, logic signed [9:0] value, logic last_flag);
      mouse_event_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_kind %0d event_value %0d last %0d",
               kind, value, last_flag);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      events_checked++;
      if (kind !== want.kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $error("event_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last: expected %0d, got %0d", want.last_flag, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_index_i   = 1'b0;
  logic [1:0]        cfg_data_i    = 2'd0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i   = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [3:0]        event_kind_o;
  logic signed [9:0] event_value_o;
  logic              last_o;

  mouse_event_board board = new();
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      bytes_sent    = 0;
  int unsigned      cycle_count   = 0;

  ps2_mouse_packet_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_value_o (event_value_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the event output at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every event transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_event(event_kind_o, event_value_o, last_o);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Write one register; call just after a falling edge
  task automatic write_reg(input logic idx, input logic [1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one byte, with random gaps before it, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    bit was_enabled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    was_enabled = board.enable;
    board.decode_byte(b);
    if (was_enabled) bytes_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Hold off until every expected event has arrived and the pipeline is empty
  task automatic wait_drained();
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send one well-formed packet with random content for the current format
  task automatic send_packet();
    logic [7:0] head;
    int         n;
    head = 8'($urandom) | 8'h08;
    if ($urandom_range(99) < 80) head[7:6] = 2'b00;
    n = (board.fmt == FMT_WHEEL || board.fmt == FMT_EXPLORER) ? 3 : 2;
    send_byte(head);
    for (int i = 0; i < n; i++) begin
      send_byte(($urandom_range(99) < 25) ? 8'h00 : 8'($urandom));
    end
  endtask

  // Mostly packets, some stray bytes that may break the framing
  task automatic run_random(input int unsigned n);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(99) < 85) begin
        send_packet();
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 18;
    recv_idle_pct = 76;
    write_reg(CFG_ENABLE, 2'd1);
    write_reg(CFG_FORMAT, FMT_STANDARD);

    // Drop a first byte without sync; then a packet with nothing changed
    send_byte(8'h00);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    // Largest negative motion, three buttons pressed
    send_byte(8'h3F); send_byte(8'h00); send_byte(8'h00);
    // Overflow zeroes motion; buttons released
    send_byte(8'hC8); send_byte(8'h7F); send_byte(8'h7F);

    wait_drained();
    write_reg(CFG_FORMAT, FMT_WHEEL);
    send_byte(8'h08); send_byte(8'h01); send_byte(8'hFF); send_byte(8'h80);

    wait_drained();
    write_reg(CFG_FORMAT, FMT_EXPLORER);
    send_byte(8'h0C); send_byte(8'h00); send_byte(8'h00); send_byte(8'h38);

    // Side and extra read as released outside explorer mode
    wait_drained();
    write_reg(CFG_FORMAT, FMT_STANDARD);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);

    // Shrink the format with three bytes held; the next byte closes the packet
    wait_drained();
    write_reg(CFG_FORMAT, FMT_WHEEL);
    send_byte(8'h09); send_byte(8'h05); send_byte(8'h06);
    wait_drained();
    write_reg(CFG_FORMAT, FMT_STANDARD);
    send_byte(8'hAA);

    // Unused format code; disabling mid-packet keeps the position
    wait_drained();
    write_reg(CFG_FORMAT, FMT_UNUSED);
    send_byte(8'h0A); send_byte(8'h10);
    wait_drained();
    write_reg(CFG_ENABLE, 2'd0);
    send_byte(8'h00); send_byte(8'hFF);
    write_reg(CFG_ENABLE, 2'd1);
    send_byte(8'h20);

    // Sender side idles little, receiver stalls often
    wait_drained();
    write_reg(CFG_FORMAT, FMT_WHEEL);
    run_random(28);
    wait_drained();
    run_random(28);

    // Swap the idling; include a stretch with the mouse switched off
    wait_drained();
    send_idle_pct = 76;
    recv_idle_pct = 18;
    write_reg(CFG_FORMAT, FMT_EXPLORER);
    run_random(28);
    wait_drained();
    write_reg(CFG_ENABLE, 2'd0);
    for (int i = 0; i < 6; i++) send_byte(8'($urandom));
    write_reg(CFG_ENABLE, 2'd1);
    run_random(28);

    // Full rate on both sides, explorer then standard
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(28);
    wait_drained();
    write_reg(CFG_FORMAT, FMT_STANDARD);
    run_random(28);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.pending_events.size() != 0) begin
      $error("%0d expected events never arrived", board.pending_events.size());
      board.errors++;
    end
    $display("tb_top: %0d bytes sent, %0d packets decoded, %0d events checked",
             bytes_sent, board.packets_done, board.events_checked);
    $display("tb_top: covered standard, wheel, explorer and unused formats with output stalls");
    if (board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mpd_pkg.sv
sv/mpd_front.sv
sv/mpd_fifo.sv
sv/mpd_back.sv
sv/ps2_mouse_packet_decoder.sv
tb/tb_top.sv
